@@ hdl/hwla_pkg.sv @@
// shared types and constants of the hue wheel light animator
// no dependencies; used by the color stage and the top level
`timescale 1ns / 1ps

package hwla_pkg;

   // command codes of the input channel
   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_LOAD = 1'b1;

   // register map: register index taken from paddr[2]
   localparam logic REG_STEP_INCREMENT = 1'b0;
   localparam logic [7:0] STEP_INCREMENT_RESET = 8'd8;

   localparam int RAMP_LEN = 256;
   localparam logic [7:0] COLOR_FULL = 8'hff;
   localparam logic [7:0] COLOR_OFF = 8'h00;

   // hue wheel segments
   typedef enum logic [2:0] {
      SEG_RED_YELLOW    = 3'd0,
      SEG_YELLOW_GREEN  = 3'd1,
      SEG_GREEN_CYAN    = 3'd2,
      SEG_CYAN_BLUE     = 3'd3,
      SEG_BLUE_MAGENTA  = 3'd4,
      SEG_MAGENTA_RED   = 3'd5
   } hue_seg_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_LOAD = 3'b010,
      ST_TICK = 3'b100
   } ctrl_state_type;

endpackage

@@ hdl/hwla_phase_mem.sv @@
// phase memory: one write port, one registered read port, valid bit per entry
// entries never written read as zero; no package dependency
`timescale 1ns / 1ps

module hwla_phase_mem #(
   parameter int DEPTH = 50,
   parameter int ADDR_W = 6,
   parameter int WIDTH = 13
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [WIDTH-1:0] rdata_ff;
   logic             rvalid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rvalid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rvalid_ff ? rdata_ff : '0;

endmodule

@@ hdl/hwla_color_stage.sv @@
// color stage: splits a wrapped phase into segment and offset, builds rgb,
// and holds the result in the output register; uses hwla_pkg
`timescale 1ns / 1ps

module hwla_color_stage #(
   parameter int PHASE_W = 13,
   parameter int SEG_LEN = 1256,
   parameter int ADDR_W = 6
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_free,
   input  logic [PHASE_W-1:0] in_phase,
   input  logic [ADDR_W-1:0]  in_index,
   input  logic               in_last,
   output logic               busy,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [5:0]         rsp_light_number,
   output logic [7:0]         rsp_red,
   output logic [7:0]         rsp_green,
   output logic [7:0]         rsp_blue,
   output logic               rsp_last
);

   import hwla_pkg::*;

   logic               s2_valid_ff, s2_valid_in;
   logic [PHASE_W-1:0] s2_phase_ff;
   logic [ADDR_W-1:0]  s2_index_ff;
   logic               s2_last_ff;
   logic               out_valid_ff, out_valid_in;
   logic [5:0]         out_number_ff;
   logic [7:0]         out_red_ff, out_green_ff, out_blue_ff;
   logic               out_last_ff;

   logic               out_free, s2_adv;
   hue_seg_type        seg;
   logic [PHASE_W-1:0] seg_base, seg_off;
   logic [7:0]         ramp;
   logic [7:0]         red, green, blue;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign s2_adv = s2_valid_ff && out_free;
   assign in_free = !s2_valid_ff || s2_adv;
   assign busy = s2_valid_ff;

   // segment by parallel compares against the segment boundaries
   always_comb begin
      seg = SEG_RED_YELLOW;
      seg_base = '0;
      for (int j = 1; j < 6; j++) begin
         if (s2_phase_ff >= PHASE_W'(j * SEG_LEN)) begin
            seg = hue_seg_type'(3'(j));
            seg_base = PHASE_W'(j * SEG_LEN);
         end
      end
      seg_off = s2_phase_ff - seg_base;
      // hold at full ramp for the rest of the segment
      ramp = (seg_off > PHASE_W'(RAMP_LEN - 1)) ? COLOR_FULL : seg_off[7:0];
   end

   always_comb begin
      unique case (seg)
         SEG_RED_YELLOW: begin
            red = COLOR_FULL; green = ramp; blue = COLOR_OFF;
         end
         SEG_YELLOW_GREEN: begin
            red = COLOR_FULL - ramp; green = COLOR_FULL; blue = COLOR_OFF;
         end
         SEG_GREEN_CYAN: begin
            red = COLOR_OFF; green = COLOR_FULL; blue = ramp;
         end
         SEG_CYAN_BLUE: begin
            red = COLOR_OFF; green = COLOR_FULL - ramp; blue = COLOR_FULL;
         end
         SEG_BLUE_MAGENTA: begin
            red = ramp; green = COLOR_OFF; blue = COLOR_FULL;
         end
         default: begin
            red = COLOR_FULL; green = COLOR_OFF; blue = COLOR_FULL - ramp;
         end
      endcase
   end

   assign s2_valid_in = (in_valid && in_free) ? 1'b1 : (s2_adv ? 1'b0 : s2_valid_ff);
   assign out_valid_in = s2_adv ? 1'b1 : (out_free ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_free) begin
         s2_phase_ff <= in_phase;
         s2_index_ff <= in_index;
         s2_last_ff <= in_last;
      end
      if (s2_adv) begin
         out_number_ff <= 6'(s2_index_ff);
         out_red_ff <= red;
         out_green_ff <= green;
         out_blue_ff <= blue;
         out_last_ff <= s2_last_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_light_number = out_number_ff;
   assign rsp_red = out_red_ff;
   assign rsp_green = out_green_ff;
   assign rsp_blue = out_blue_ff;
   assign rsp_last = out_last_ff;

endmodule

@@ hdl/hue_wheel_light_animator_unit.sv @@
// top level of the hue wheel light animator: control, register port, update stage
// instantiates hwla_phase_mem and hwla_color_stage; uses hwla_pkg
//
// usage:
//   req channel (valid/stall) takes a command: tick advances every light by
//   step_increment and returns one rgb transfer per light, light 0 first, with
//   rsp_last on the final one; load writes one light's phase and returns nothing.
//   a load to a light number at or beyond NUM_LIGHTS is dropped.
//   a tick handles one light per cycle while the receiver does not stall, a rate
//   set by the single read port of the phase memory. the first color passes
//   the phase memory read register, then the color stage input and output registers.
//   a load folds the phase into the wheel by subtracting the wheel length
//   until it fits, and only then writes it.
//   req_stall is high while a command is in progress; one item at a time.
//   a stalled rsp transfer holds its register and the pipeline behind it waits;
//   no memory read is issued until there is room.
//   reset clears the valid bits of the phase memory (all phases read as zero)
//   and sets step_increment to 8; csr writes take effect at once, reads
//   return step_increment at address 0.
`timescale 1ns / 1ps

module hue_wheel_light_animator_unit #(
   parameter int NUM_LIGHTS = 50,
   parameter int HOLD_TICKS = 1000
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [5:0]  req_light_index,
   input  logic [12:0] req_phase_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_light_number,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic        rsp_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   import hwla_pkg::*;

   localparam int SEG_LEN = RAMP_LEN + HOLD_TICKS;
   localparam int WHEEL_LEN = 6 * SEG_LEN;
   localparam int ADDR_W = (NUM_LIGHTS > 1) ? $clog2(NUM_LIGHTS) : 1;
   localparam int PHASE_W = $clog2(WHEEL_LEN);
   localparam int SUM_W = PHASE_W + 1;
   localparam int LOAD_W = (PHASE_W > 13) ? PHASE_W : 13;
   localparam logic [SUM_W-1:0] WHEEL_S = SUM_W'(WHEEL_LEN);
   localparam logic [LOAD_W:0] WHEEL_L = (LOAD_W + 1)'(WHEEL_LEN);
   localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(NUM_LIGHTS - 1);

   ctrl_state_type     state_ff, state_in;
   logic [7:0]         step_ff;
   logic [LOAD_W-1:0]  load_val_ff, load_val_in;
   logic [ADDR_W-1:0]  load_addr_ff;
   logic [ADDR_W-1:0]  issue_idx_ff;
   logic               issue_done_ff;
   logic               s1_valid_ff, s1_valid_in;
   logic [ADDR_W-1:0]  s1_idx_ff;
   logic               s1_last_ff;

   logic               req_xfer, csr_write, load_fits, load_write;
   logic               issue, s1_adv, s1_free, s2_free, s2_busy;
   logic [PHASE_W-1:0] rd_data, wr_data, s1_phase;
   logic [ADDR_W-1:0]  wr_addr;
   logic [SUM_W-1:0]   sum;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer = req_valid && !req_stall;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_STEP_INCREMENT) ? {24'b0, step_ff} : 32'b0;

   assign load_fits = ({1'b0, load_val_ff} < WHEEL_L);
   assign load_write = (state_ff == ST_LOAD) && load_fits;

   // tick pipeline flow control
   assign s1_adv = s1_valid_ff && s2_free;
   assign s1_free = !s1_valid_ff || s1_adv;
   assign issue = (state_ff == ST_TICK) && !issue_done_ff && s1_free;
   assign s1_valid_in = issue ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);

   // add the step and wrap once; stored phases always lie inside the wheel
   assign sum = {1'b0, rd_data} + SUM_W'(step_ff);
   assign s1_phase = PHASE_W'((sum >= WHEEL_S) ? (sum - WHEEL_S) : sum);

   assign wr_addr = load_write ? load_addr_ff : s1_idx_ff;
   assign wr_data = load_write ? PHASE_W'(load_val_ff) : s1_phase;

   always_comb begin
      state_in = state_ff;
      load_val_in = load_val_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_command == CMD_TICK) begin
                  state_in = ST_TICK;
               end else if ({1'b0, req_light_index} < 7'(NUM_LIGHTS)) begin
                  state_in = ST_LOAD;
                  load_val_in = LOAD_W'(req_phase_value);
               end
            end
         end
         ST_LOAD: begin
            // fold the loaded phase into the wheel, one subtraction a cycle
            if (load_fits) begin
               state_in = ST_IDLE;
            end else begin
               load_val_in = load_val_ff - LOAD_W'(WHEEL_LEN);
            end
         end
         ST_TICK: begin
            if (issue_done_ff && !s1_valid_ff && !s2_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= STEP_INCREMENT_RESET;
         issue_idx_ff <= '0;
         issue_done_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         s1_valid_ff <= s1_valid_in;
         if (csr_write && csr_paddr[2] == REG_STEP_INCREMENT) begin
            step_ff <= csr_pwdata[7:0];
         end
         if (req_xfer) begin
            issue_idx_ff <= '0;
            issue_done_ff <= 1'b0;
         end else if (issue) begin
            issue_idx_ff <= issue_idx_ff + 1'b1;
            issue_done_ff <= (issue_idx_ff == LAST_IDX);
         end
      end
   end

   always_ff @(posedge clock) begin
      load_val_ff <= load_val_in;
      if (req_xfer) begin
         load_addr_ff <= ADDR_W'(req_light_index);
      end
      if (issue) begin
         s1_idx_ff <= issue_idx_ff;
         s1_last_ff <= (issue_idx_ff == LAST_IDX);
      end
   end

   hwla_phase_mem #(
      .DEPTH  (NUM_LIGHTS),
      .ADDR_W (ADDR_W),
      .WIDTH  (PHASE_W)
   ) u_phase_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (issue),
      .rd_addr (issue_idx_ff),
      .rd_data (rd_data),
      .wr_en   (load_write || s1_adv),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   hwla_color_stage #(
      .PHASE_W (PHASE_W),
      .SEG_LEN (SEG_LEN),
      .ADDR_W  (ADDR_W)
   ) u_color_stage (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (s1_valid_ff),
      .in_free          (s2_free),
      .in_phase         (s1_phase),
      .in_index         (s1_idx_ff),
      .in_last          (s1_last_ff),
      .busy             (s2_busy),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_light_number (rsp_light_number),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .rsp_last         (rsp_last)
   );

endmodule
